// File: hw/rtl/bfm_pkg.sv
// ----------------------------------------------------------------------------
// bfm_pkg
// Shared constants and types of the box filter mean unit.
// ----------------------------------------------------------------------------
package bfm_pkg;

  localparam int RADIUS_DEF     = 10;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int PIX_W     = 8;
  localparam int DIM_W     = 11;
  localparam int DIM_RESET = 1024;
  localparam int DATA_W    = 32;
  localparam int PADDR_W   = 3;

  // register index codes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // input word codes
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int OBUF_DEPTH  = 8;

  // per-word control flags from front to back
  typedef struct packed {
    logic write;     // pixel goes into the line store
    logic emit;      // word produces a result
    logic interior;  // result is the window mean
    logic last;      // result is the final pixel of the frame
    logic row0;      // input pixel sits on row 0
    logic rowfull;   // input row has a full column of history
    logic col0;      // input pixel sits on column 0
    logic colfull;   // input column has a full span to its left
  } ctl_t;

endpackage

// File: hw/rtl/bfm_ram.sv
// ----------------------------------------------------------------------------
// bfm_ram
// Simple dual-port RAM, one write and one registered read, read-first.
// ----------------------------------------------------------------------------
module bfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

// File: hw/rtl/bfm_queue.sv
// ----------------------------------------------------------------------------
// bfm_queue
// Small register FIFO with occupancy count.
// ----------------------------------------------------------------------------
module bfm_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           pop_data,
  output logic                       empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;

  assign empty    = (count == '0);
  assign full     = (32'(count) == DEPTH);
  assign pop_data = slots[head];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (32'(tail) == DEPTH - 1) ? '0 : tail + 1'b1;
      end
      if (pop) begin
        head <= (32'(head) == DEPTH - 1) ? '0 : head + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hw/rtl/bfm_front.sv
// ----------------------------------------------------------------------------
// bfm_front
// Register port, frame position tracking and word classification.
// ----------------------------------------------------------------------------
module bfm_front #(
  parameter int RADIUS     = bfm_pkg::RADIUS_DEF,
  parameter int MAX_WIDTH  = bfm_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bfm_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [bfm_pkg::PADDR_W-1:0]          paddr,
  input  logic [bfm_pkg::DATA_W-1:0]           pwdata,
  output logic [bfm_pkg::DATA_W-1:0]           prdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 cmd,
  input  logic [bfm_pkg::PIX_W-1:0]            pixel_in,
  input  logic                                 q_full,
  output logic                                 push,
  output bfm_pkg::ctl_t                        ctl,
  output logic [bfm_pkg::PIX_W-1:0]            pix,
  output logic [$clog2(2*RADIUS+1)-1:0]        in_slot,
  output logic [$clog2(MAX_WIDTH)-1:0]         in_col,
  output logic [$clog2(2*RADIUS+1)-1:0]        out_slot,
  output logic [$clog2(MAX_WIDTH)-1:0]         out_col
);
  import bfm_pkg::*;

  localparam int SPAN  = 2 * RADIUS + 1;
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int DLY_W = $clog2(RADIUS * MAX_WIDTH + RADIUS + 1);
  localparam int RST_W = (DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : DIM_RESET;
  localparam int RST_H = (DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : DIM_RESET;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int hi);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > hi) begin
      r = DIM_W'(hi);
    end
    return r;
  endfunction

  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  logic [DLY_W-1:0] dly;
  logic [DLY_W-1:0] cnt;
  logic [ROW_W-1:0] in_row;
  logic [ROW_W-1:0] out_row;
  logic             draining;

  logic             wr;
  logic             accept;
  logic             is_pix;
  logic             primed;
  logic             emit_now;
  logic             in_col_end;
  logic             in_last;
  logic             out_col_end;
  logic             out_last;
  logic [DIM_W-1:0] wr_dim;

  assign wr       = psel && penable && pwrite;
  assign wr_dim   = pwdata[DIM_W-1:0];
  assign prdata   = (paddr[2] == REG_HEIGHT) ? DATA_W'(frame_height) : DATA_W'(frame_width);
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_pix   = (cmd == CMD_PIXEL) && !draining;
  assign primed   = (cnt == dly);
  assign emit_now = accept && (draining || (is_pix && primed));

  assign in_col_end  = (32'(in_col) + 1) == 32'(frame_width);
  assign in_last     = in_col_end && ((32'(in_row) + 1) == 32'(frame_height));
  assign out_col_end = (32'(out_col) + 1) == 32'(frame_width);
  assign out_last    = out_col_end && ((32'(out_row) + 1) == 32'(frame_height));

  assign push = accept && (draining || cmd == CMD_PIXEL);
  assign pix  = pixel_in;

  always_comb begin
    ctl.write    = !draining;
    ctl.emit     = draining || primed;
    ctl.interior = !draining && primed && (32'(in_row) >= 2 * RADIUS)
                   && (32'(in_col) >= 2 * RADIUS);
    ctl.last     = out_last;
    ctl.row0     = (in_row == '0);
    ctl.rowfull  = (32'(in_row) >= SPAN);
    ctl.col0     = (in_col == '0);
    ctl.colfull  = (32'(in_col) >= SPAN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DIM_W'(RST_W);
      frame_height <= DIM_W'(RST_H);
      dly          <= DLY_W'(RADIUS * RST_W + RADIUS);
      cnt          <= '0;
      in_row       <= '0;
      in_col       <= '0;
      in_slot      <= '0;
      out_row      <= '0;
      out_col      <= '0;
      out_slot     <= '0;
      draining     <= 1'b0;
    end else if (wr) begin
      case (paddr[2])
        REG_WIDTH: begin
          frame_width <= clamp_dim(wr_dim, MAX_WIDTH);
          dly <= DLY_W'(RADIUS * 32'(clamp_dim(wr_dim, MAX_WIDTH)) + RADIUS);
        end
        REG_HEIGHT: begin
          frame_height <= clamp_dim(wr_dim, MAX_HEIGHT);
        end
        default: begin
          frame_width <= frame_width;
        end
      endcase
      cnt      <= '0;
      in_row   <= '0;
      in_col   <= '0;
      in_slot  <= '0;
      out_row  <= '0;
      out_col  <= '0;
      out_slot <= '0;
      draining <= 1'b0;
    end else if (accept) begin
      if (emit_now) begin
        if (out_last) begin
          out_row  <= '0;
          out_col  <= '0;
          out_slot <= '0;
          draining <= 1'b0;
        end else if (out_col_end) begin
          out_col  <= '0;
          out_row  <= out_row + 1'b1;
          out_slot <= (32'(out_slot) == SPAN - 1) ? '0 : out_slot + 1'b1;
        end else begin
          out_col <= out_col + 1'b1;
        end
      end
      if (is_pix) begin
        if (in_last) begin
          cnt <= '0;
        end else if (!primed) begin
          cnt <= cnt + 1'b1;
        end
        if (in_last) begin
          in_row   <= '0;
          in_col   <= '0;
          in_slot  <= '0;
          draining <= 1'b1;
        end else if (in_col_end) begin
          in_col  <= '0;
          in_row  <= in_row + 1'b1;
          in_slot <= (32'(in_slot) == SPAN - 1) ? '0 : in_slot + 1'b1;
        end else begin
          in_col <= in_col + 1'b1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_drain_in_home: assert property (@(posedge clk) disable iff (rst)
    draining |-> (in_row == '0 && in_col == '0 && cnt == '0))
    else $error("input position not at frame start while draining");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= dly)
    else $error("lead counter passed the delay");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("word pushed into a full queue");
`endif

endmodule

// File: hw/rtl/bfm_back.sv
// ----------------------------------------------------------------------------
// bfm_back
// Line store, column and window sums, mean division and result select.
// ----------------------------------------------------------------------------
module bfm_back #(
  parameter int RADIUS    = bfm_pkg::RADIUS_DEF,
  parameter int MAX_WIDTH = bfm_pkg::MAX_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   q_empty,
  output logic                                   q_pop,
  input  bfm_pkg::ctl_t                          ctl,
  input  logic [bfm_pkg::PIX_W-1:0]              pix,
  input  logic [$clog2(2*RADIUS+1)-1:0]          in_slot,
  input  logic [$clog2(MAX_WIDTH)-1:0]           in_col,
  input  logic [$clog2(2*RADIUS+1)-1:0]          out_slot,
  input  logic [$clog2(MAX_WIDTH)-1:0]           out_col,
  input  logic [$clog2(bfm_pkg::OBUF_DEPTH+1)-1:0] ob_count,
  output logic                                   ob_push,
  output logic [bfm_pkg::PIX_W-1:0]              ob_pixel,
  output logic                                   ob_last
);
  import bfm_pkg::*;

  localparam int SPAN    = 2 * RADIUS + 1;
  localparam int AREA    = SPAN * SPAN;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ADDR_W  = $clog2(SPAN * MAX_WIDTH);
  localparam int CS_W    = $clog2(SPAN * 255 + 1);
  localparam int SUM_W   = $clog2(AREA * 255 + 1);
  localparam int RECIP   = (2 ** SUM_W) / AREA;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int PROD_W  = SUM_W + RECIP_W;

  // B0: pop and RAM access
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] pass_addr;
  logic [PIX_W-1:0]  old_q;
  logic [PIX_W-1:0]  pass_q;
  logic [CS_W-1:0]   cs_q;
  logic [2:0]        inflight;

  // B1
  logic             v1;
  ctl_t             c1;
  logic [PIX_W-1:0] p1;
  logic [COL_W-1:0] col1;
  logic [CS_W-1:0]  cs_base;
  logic [CS_W-1:0]  cs_new;
  logic             fwd;

  // B2
  logic             v2;
  ctl_t             c2;
  logic [COL_W-1:0] col2;
  logic [CS_W-1:0]  cs2;
  logic [PIX_W-1:0] pass2;
  logic [SUM_W-1:0] ws;
  logic [SUM_W-1:0] ws_next;
  logic [CS_W-1:0]  taps [SPAN];

  // B3
  logic             v3;
  ctl_t             c3;
  logic [SUM_W-1:0] sum3;
  logic [PIX_W-1:0] pass3;

  // B4
  logic              v4;
  ctl_t              c4;
  logic [SUM_W-1:0]  sum4;
  logic [PIX_W-1:0]  pass4;
  logic [PROD_W-1:0] prod4;
  logic [RECIP_W-1:0] q0;
  logic [PROD_W-1:0] rem;
  logic [RECIP_W-1:0] quot;

  // only words that give a result need a buffer slot
  assign inflight = 3'(v1 && c1.emit) + 3'(v2 && c2.emit) + 3'(v3 && c3.emit)
                  + 3'(v4 && c4.emit);
  assign q_pop = !q_empty && (32'(ob_count) + 32'(inflight) < OBUF_DEPTH);

  assign wr_addr   = ADDR_W'(in_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_col);
  assign pass_addr = ADDR_W'(out_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(out_col);

  // copy that returns the pixel leaving the column
  bfm_ram #(.WIDTH(PIX_W), .DEPTH(SPAN * MAX_WIDTH)) u_ls_old (
    .clk   (clk),
    .we    (q_pop && ctl.write),
    .waddr (wr_addr),
    .wdata (pix),
    .raddr (wr_addr),
    .rdata (old_q)
  );

  // copy that returns the border pass-through pixel
  bfm_ram #(.WIDTH(PIX_W), .DEPTH(SPAN * MAX_WIDTH)) u_ls_pass (
    .clk   (clk),
    .we    (q_pop && ctl.write),
    .waddr (wr_addr),
    .wdata (pix),
    .raddr (pass_addr),
    .rdata (pass_q)
  );

  bfm_ram #(.WIDTH(CS_W), .DEPTH(MAX_WIDTH)) u_colsum (
    .clk   (clk),
    .we    (v1 && c1.write),
    .waddr (col1),
    .wdata (cs_new),
    .raddr (in_col),
    .rdata (cs_q)
  );

  // back-to-back update of one column (one-pixel-wide rows)
  assign fwd = v2 && c2.write && (col2 == col1);

  always_comb begin
    if (c1.row0) begin
      cs_base = '0;
    end else if (fwd) begin
      cs_base = cs2;
    end else begin
      cs_base = cs_q;
    end
    cs_new = cs_base + CS_W'(p1) - (c1.rowfull ? CS_W'(old_q) : '0);
  end

  assign ws_next = (c2.col0 ? '0 : ws) + SUM_W'(cs2)
                 - (c2.colfull ? SUM_W'(taps[SPAN-1]) : '0);

  assign q0   = prod4[PROD_W-1:SUM_W];
  assign rem  = PROD_W'(sum4) - PROD_W'(q0) * PROD_W'(AREA);
  assign quot = (rem >= PROD_W'(AREA)) ? q0 + 1'b1 : q0;

  assign ob_push  = v4 && c4.emit;
  assign ob_pixel = c4.interior ? quot[PIX_W-1:0] : pass4;
  assign ob_last  = c4.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= q_pop;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    c1    <= ctl;
    p1    <= pix;
    col1  <= in_col;
    c2    <= c1;
    col2  <= col1;
    cs2   <= cs_new;
    pass2 <= pass_q;
    c3    <= c2;
    sum3  <= ws_next;
    pass3 <= pass2;
    c4    <= c3;
    sum4  <= sum3;
    pass4 <= pass3;
    prod4 <= PROD_W'(sum3) * PROD_W'(RECIP);
    if (v2 && c2.write) begin
      ws      <= ws_next;
      taps[0] <= cs2;
      for (int i = 1; i < SPAN; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

endmodule

// File: hw/rtl/box_filter_mean_21x21_unit.sv
// ----------------------------------------------------------------------------
// box_filter_mean_21x21_unit: 2-D box mean filter, pixel stream in and out.
// Throughput one word per cycle while the descriptor queue is not full, set by the
// per-pixel column-sum RAM update. Each result passes the descriptor queue, the back
// pipe registers and the result buffer before it shows on out_valid.
// Reset clears control only; line store is never cleared.
// ----------------------------------------------------------------------------
module box_filter_mean_21x21_unit #(
  parameter int RADIUS     = bfm_pkg::RADIUS_DEF,
  parameter int MAX_WIDTH  = bfm_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bfm_pkg::MAX_HEIGHT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bfm_pkg::PADDR_W-1:0] paddr,
  input  logic [bfm_pkg::DATA_W-1:0]  pwdata,
  output logic [bfm_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        cmd,
  input  logic [bfm_pkg::PIX_W-1:0]   pixel_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bfm_pkg::PIX_W-1:0]   pixel_out,
  output logic                        frame_last
);
  import bfm_pkg::*;

  // Front tracks input and output raster positions, decides per word
  // whether it writes the line store and whether it gives a result, and
  // pushes a descriptor into a short queue. Back does the line store /
  // column sum RAM access in the pop cycle, then 4 register stages:
  // column sum update, window sum, reciprocal multiply, remainder fix-up.
  // Back pops only when the output buffer has room for every result still
  // in the pipe, so no stage stalls.

  localparam int SPAN   = 2 * RADIUS + 1;
  localparam int SLOT_W = $clog2(SPAN);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int CTL_W  = $bits(ctl_t);
  localparam int QW     = CTL_W + PIX_W + 2 * SLOT_W + 2 * COL_W;
  localparam int OW     = PIX_W + 1;

  ctl_t               f_ctl;
  logic [PIX_W-1:0]   f_pix;
  logic [SLOT_W-1:0]  f_in_slot;
  logic [COL_W-1:0]   f_in_col;
  logic [SLOT_W-1:0]  f_out_slot;
  logic [COL_W-1:0]   f_out_col;
  logic               f_push;

  logic [QW-1:0]      q_wdata;
  logic [QW-1:0]      q_rdata;
  logic               q_empty;
  logic               q_full;
  logic               q_pop;

  ctl_t               b_ctl;
  logic [PIX_W-1:0]   b_pix;
  logic [SLOT_W-1:0]  b_in_slot;
  logic [COL_W-1:0]   b_in_col;
  logic [SLOT_W-1:0]  b_out_slot;
  logic [COL_W-1:0]   b_out_col;

  logic               ob_push;
  logic [PIX_W-1:0]   ob_pixel;
  logic               ob_last;
  logic [OW-1:0]      ob_rdata;
  logic               ob_empty;
  logic [$clog2(OBUF_DEPTH+1)-1:0] ob_count;

  assign pready = 1'b1;

  bfm_front #(.RADIUS(RADIUS), .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .pixel_in (pixel_in),
    .q_full   (q_full),
    .push     (f_push),
    .ctl      (f_ctl),
    .pix      (f_pix),
    .in_slot  (f_in_slot),
    .in_col   (f_in_col),
    .out_slot (f_out_slot),
    .out_col  (f_out_col)
  );

  assign q_wdata = {f_ctl, f_pix, f_in_slot, f_in_col, f_out_slot, f_out_col};

  // descriptor queue between front and back
  bfm_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty),
    .full      (q_full),
    .count     ()
  );

  assign {b_ctl, b_pix, b_in_slot, b_in_col, b_out_slot, b_out_col} = q_rdata;

  bfm_back #(.RADIUS(RADIUS), .MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .ctl      (b_ctl),
    .pix      (b_pix),
    .in_slot  (b_in_slot),
    .in_col   (b_in_col),
    .out_slot (b_out_slot),
    .out_col  (b_out_col),
    .ob_count (ob_count),
    .ob_push  (ob_push),
    .ob_pixel (ob_pixel),
    .ob_last  (ob_last)
  );

  // result buffer: absorbs the pipe when the sink stalls
  bfm_queue #(.WIDTH(OW), .DEPTH(OBUF_DEPTH)) u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (ob_push),
    .push_data ({ob_pixel, ob_last}),
    .pop       (out_valid && out_ready),
    .pop_data  (ob_rdata),
    .empty     (ob_empty),
    .full      (),
    .count     (ob_count)
  );

  assign out_valid  = !ob_empty;
  assign pixel_out  = ob_rdata[OW-1:1];
  assign frame_last = ob_rdata[0];

endmodule

// File: bench/box_filter_mean_21x21_unit_check.sv
// ----------------------------------------------------------------------------
// box_filter_mean_21x21_unit_check
// Watches the register port and both word channels, predicts the filtered
// stream and compares each output word with the oldest predicted word.
// ----------------------------------------------------------------------------
module box_filter_mean_21x21_unit_check (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bfm_pkg::PADDR_W-1:0] paddr,
  input  logic [bfm_pkg::DATA_W-1:0]  pwdata,
  input  logic                        pready,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        cmd,
  input  logic [bfm_pkg::PIX_W-1:0]   pixel_in,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [bfm_pkg::PIX_W-1:0]   pixel_out,
  input  logic                        frame_last,
  output int                          errors,
  output int                          pending
);
  import bfm_pkg::*;

  localparam int R    = RADIUS_DEF;
  localparam int SPAN = 2 * R + 1;
  localparam int AREA = SPAN * SPAN;
  localparam int MW   = MAX_WIDTH_DEF;

  typedef struct {
    logic [PIX_W-1:0] pix;
    logic             last;
  } out_word_t;

  logic [PIX_W-1:0] rows_seen [SPAN*MW];
  out_word_t        mean_q[$];
  int               fw, fh, irow, icol, orow, ocol;
  bit               drain;

  function automatic int clamp_dim(logic [DATA_W-1:0] v, int hi);
    int d;
    d = int'(v[DIM_W-1:0]);
    if (d < 1) return 1;
    if (d > hi) return hi;
    return d;
  endfunction

  function automatic logic [PIX_W-1:0] hist(int r, int c);
    return rows_seen[(r % SPAN) * MW + (c % MW)];
  endfunction

  // next output word of the frame; advances the output position
  function automatic out_word_t next_mean();
    out_word_t o;
    int        acc;
    acc = 0;
    if (orow >= R && orow + R < fh && ocol >= R && ocol + R < fw) begin
      for (int dr = 0; dr < SPAN; dr++)
        for (int dc = 0; dc < SPAN; dc++)
          acc += hist(orow - R + dr, ocol - R + dc);
      o.pix = PIX_W'(acc / AREA);
    end else begin
      o.pix = hist(orow, ocol);
    end
    o.last = (orow + 1 >= fh) && (ocol + 1 >= fw);
    if (o.last) begin
      orow  = 0;
      ocol  = 0;
      drain = 0;
    end else if (ocol + 1 >= fw) begin
      ocol = 0;
      orow++;
    end else begin
      ocol++;
    end
    return o;
  endfunction

  task automatic take_word(logic c, logic [PIX_W-1:0] p);
    int idx;
    if (c == CMD_FLUSH || drain) begin
      if (drain) mean_q.push_back(next_mean());
      return;
    end
    rows_seen[(irow % SPAN) * MW + (icol % MW)] = p;
    idx = irow * fw + icol;
    icol++;
    if (icol >= fw) begin
      icol = 0;
      irow++;
      if (irow >= fh) begin
        irow  = 0;
        drain = 1;
      end
    end
    if (idx >= R * fw + R) mean_q.push_back(next_mean());
  endtask

  always @(posedge clk) begin
    out_word_t e;
    if (rst) begin
      fw = DIM_RESET; fh = DIM_RESET;
      irow = 0; icol = 0; orow = 0; ocol = 0; drain = 0;
      mean_q.delete();
      errors = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_WIDTH) fw = clamp_dim(pwdata, MAX_WIDTH_DEF);
        else                       fh = clamp_dim(pwdata, MAX_HEIGHT_DEF);
        irow = 0; icol = 0; orow = 0; ocol = 0; drain = 0;
      end
      if (in_valid && in_ready) take_word(cmd, pixel_in);
      if (out_valid && out_ready) begin
        if (mean_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected word: pixel_out=%0d frame_last=%0b", pixel_out, frame_last);
        end else begin
          e = mean_q.pop_front();
          if (pixel_out !== e.pix || frame_last !== e.last) begin
            errors++;
            if (errors <= 10)
              $display("word mismatch: expected pixel %0d last %0b, got pixel %0d last %0b",
                       e.pix, e.last, pixel_out, frame_last);
          end
        end
      end
    end
    pending = mean_q.size();
  end

  initial begin
    errors  = 0;
    pending = 0;
  end

endmodule

// File: bench/box_filter_mean_21x21_unit_test.sv
// ----------------------------------------------------------------------------
// box_filter_mean_21x21_unit_test
// Drives frames of pixels and flush words through the box mean filter under
// random idling on both channels; a checker predicts every output word.
// ----------------------------------------------------------------------------
module box_filter_mean_21x21_unit_test;
  import bfm_pkg::*;

  localparam int R         = RADIUS_DEF;
  localparam int LIMIT     = 3_000_000;   // cycles
  localparam int WORDS     = 1650;

  logic                clk = 0;
  logic                rst = 1;
  logic                psel = 0, penable = 0, pwrite = 0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid = 0, in_ready;
  logic                cmd = CMD_PIXEL;
  logic [PIX_W-1:0]    pixel_in = '0;
  logic                out_valid, out_ready = 0;
  logic [PIX_W-1:0]    pixel_out;
  logic                frame_last;
  int                  errors, pending;
  int                  cycles = 0;
  int                  words_sent = 0;
  bit                  quiet = 0;      // sender offers back to back
  bit                  hold_req = 0;   // receiver takes a long break

  always #5 clk = ~clk;

  box_filter_mean_21x21_unit u_top (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_ready, .cmd, .pixel_in,
    .out_valid, .out_ready, .pixel_out, .frame_last
  );

  box_filter_mean_21x21_unit_check u_check (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid, .in_ready, .cmd, .pixel_in,
    .out_valid, .out_ready, .pixel_out, .frame_last,
    .errors, .pending
  );

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // receiver: random runs of ready and stall, plus one long hold on request
  initial begin
    int run;
    bit rdy;
    run = 0;
    rdy = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 0;
        run = 0;
      end else if (run == 0) begin
        rdy = ($urandom_range(0, 2) != 0);
        run = rdy ? $urandom_range(1, 40) : gap_len() + 1;
        out_ready <= rdy;
      end else begin
        run--;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("box_filter_mean_21x21_unit: mismatch");
      $finish;
    end
  end

  // one word; called at a falling edge, returns at a falling edge
  task automatic put_word(logic c, logic [PIX_W-1:0] p);
    int g;
    g = quiet ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    pixel_in <= p;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    words_sent++;
  endtask

  // all predicted words out, then the pipeline latency for flush words
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic reg_write(logic idx, logic [DATA_W-1:0] v);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // modes: 0 random, 1 all 255, 2 all 0, 3 extremes mixed with random, 4 one constant
  function automatic logic [PIX_W-1:0] pick_pix(int mode, logic [PIX_W-1:0] k);
    case (mode)
      1: return 8'hFF;
      2: return 8'h00;
      3: begin
        case ($urandom_range(0, 2))
          0: return 8'h00;
          1: return 8'hFF;
          default: return PIX_W'($urandom);
        endcase
      end
      4: return k;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // one full frame; registers are written raw so that clamping is exercised
  task automatic run_frame(logic [DATA_W-1:0] wr, logic [DATA_W-1:0] hr, int mode,
                           bit noise, bit pause_mid);
    int               w, h, n, drains;
    logic [PIX_W-1:0] k;
    reg_write(REG_WIDTH, wr);
    reg_write(REG_HEIGHT, hr);
    w = int'(wr[DIM_W-1:0]);
    h = int'(hr[DIM_W-1:0]);
    w = (w < 1) ? 1 : (w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w;
    h = (h < 1) ? 1 : (h > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : h;
    n = w * h;
    k = PIX_W'($urandom);
    for (int i = 0; i < n; i++) begin
      if (noise && $urandom_range(0, 19) == 0) put_word(CMD_FLUSH, PIX_W'($urandom));
      if (pause_mid && i == n / 2) settle();
      put_word(CMD_PIXEL, pick_pix(mode, k));
    end
    drains = (R * w + R < n) ? R * w + R : n;
    // pixels sent while draining are dropped and act as flushes
    for (int i = 0; i < drains; i++)
      put_word(($urandom_range(0, 9) < 7) ? CMD_FLUSH : CMD_PIXEL, PIX_W'($urandom));
    // flush after the frame has finished: no word
    if (noise) put_word(CMD_FLUSH, PIX_W'($urandom));
  endtask

  initial begin
    int w, h;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // 1x1 frame from zero registers; flush before the pixel gives nothing
    reg_write(REG_WIDTH, 32'h0);
    reg_write(REG_HEIGHT, 32'h0);
    put_word(CMD_FLUSH, 8'h00);
    put_word(CMD_PIXEL, 8'hA5);
    put_word(CMD_FLUSH, 8'h00);
    put_word(CMD_FLUSH, 8'hFF);

    // width value above the maximum clamps to the widest row; frame dropped
    reg_write(REG_WIDTH, 32'hFFFF_FFFF);
    reg_write(REG_HEIGHT, 32'd1);
    for (int i = 0; i < 30; i++) put_word(CMD_PIXEL, PIX_W'($urandom));

    // column of width one, height above the maximum; abandoned mid frame
    reg_write(REG_WIDTH, 32'd1);
    reg_write(REG_HEIGHT, 32'h0000_07FF);
    for (int i = 0; i < 60; i++) put_word(CMD_PIXEL, pick_pix(3, 8'h00));

    // smallest frame with an interior pixel, all 255: exact multiple of the
    // area; receiver holds off while the sender keeps pushing, then the
    // sender pauses until all words are out
    quiet = 1;
    reg_write(REG_WIDTH, 32'd21);
    reg_write(REG_HEIGHT, 32'd21);
    hold_req = 1;
    for (int i = 0; i < 441; i++) begin
      if (i == 300) settle();
      put_word(CMD_PIXEL, 8'hFF);
    end
    for (int i = 0; i < R * 21 + R; i++) put_word(CMD_FLUSH, 8'h00);
    quiet = 0;

    // random frames; small ones once the word budget runs low
    while (words_sent < WORDS) begin
      if (WORDS - words_sent >= 780) begin
        w = $urandom_range(21, 23);
        h = $urandom_range(21, 22);
      end else begin
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 12);
      end
      quiet = ($urandom_range(0, 3) == 0);
      run_frame(DATA_W'(w) | ({$urandom} & 32'hFFFF_F800), DATA_W'(h),
                $urandom_range(0, 4), $urandom_range(0, 1), 0);
    end
    quiet = 0;

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0)
      $display("box_filter_mean_21x21_unit: match");
    else
      $display("box_filter_mean_21x21_unit: mismatch");
    $finish;
  end

endmodule
